// File: hdl/go_to_goal_steering_assert.svh
// Assertion macros for the go-to-goal steering block.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef GO_TO_GOAL_STEERING_ASSERT_SVH
`define GO_TO_GOAL_STEERING_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GTG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("go_to_goal_steering: same-cycle check failed");
// next-cycle implication
`define GTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("go_to_goal_steering: next-cycle check failed");
`else
`define GTG_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/gtg_pkg.sv
// Package for the go-to-goal steering block: widths, codes, stage types
// and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

    // defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 12;
    localparam int ATAN_ENTRIES     = 24;

    // datapath widths
    localparam int DW     = 17;   // target minus position
    localparam int XW     = 34;   // CORDIC x, y, z
    localparam int EW     = 35;   // heading error
    localparam int MAG_W  = 34;   // |error|
    localparam int SUM_W  = 33;   // dx^2 + dy^2
    localparam int RAD_W  = 50;   // radicand sum << 16, padded to whole bit pairs
    localparam int ROOT_W = 25;   // square root result
    localparam int REM_W  = 27;   // square root remainder
    localparam int NCORE  = ROOT_W; // one root bit per core stage
    localparam int TURN_W = 19;

    localparam logic signed [XW-1:0] HALF_PI_U30 = 34'sd1686629714;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TARGET_X    = 2'd0,
        REG_TARGET_Y    = 2'd1,
        REG_GAIN        = 2'd2,
        REG_SPEED_LIMIT = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] TARGET_X_RST    = 16'd4096;
    localparam logic [15:0] TARGET_Y_RST    = 16'd4096;
    localparam logic [15:0] GAIN_RST        = 16'd4096;
    localparam logic [15:0] SPEED_LIMIT_RST = 16'd12288;

    // command kind
    typedef enum logic [1:0] {
        ACT_STOP  = 2'd0,
        ACT_TURN  = 2'd1,
        ACT_DRIVE = 2'd2
    } action_t;

    // stage payloads
    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [15:0]   head;
    } diff_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic [RAD_W-1:0]     rad;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
        logic signed [15:0]   head;
        logic                 far;
    } core_t;

    typedef struct packed {
        logic signed [EW-1:0] err;
        logic [ROOT_W-1:0]    root;
        logic                 far;
    } err_t;

    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic              neg;
        logic              turn;
        logic [ROOT_W-1:0] root;
        logic              far;
    } mag_t;

    typedef struct packed {
        logic [MAG_W+15:0]  pt;
        logic [ROOT_W+15:0] ps;
        logic               neg;
        logic               turn;
        logic               far;
    } prod_t;

    typedef struct packed {
        logic [15:0]            speed;
        logic signed [TURN_W-1:0] turn;
        action_t                action;
    } cmd_t;

    // atan(2^-i), truncated, units of 2^-30 rad
    function automatic logic signed [XW-1:0] atan_u30(input int idx);
        logic signed [XW-1:0] v;
        v = '0;
        unique case (idx)
            0:  v = 34'sh03243F6A8;
            1:  v = 34'sh01DAC6705;
            2:  v = 34'sh00FADBAFC;
            3:  v = 34'sh007F56EA6;
            4:  v = 34'sh003FEAB76;
            5:  v = 34'sh001FFD55B;
            6:  v = 34'sh000FFFAAA;
            7:  v = 34'sh0007FFF55;
            8:  v = 34'sh0003FFFEA;
            9:  v = 34'sh0001FFFFD;
            10: v = 34'sh0000FFFFF;
            11: v = 34'sh00007FFFF;
            12: v = 34'sh00003FFFF;
            13: v = 34'sh00001FFFF;
            14: v = 34'sh00000FFFF;
            15: v = 34'sh000007FFF;
            16: v = 34'sh000003FFF;
            17: v = 34'sh000001FFF;
            18: v = 34'sh000000FFF;
            19: v = 34'sh0000007FF;
            20: v = 34'sh0000003FF;
            21: v = 34'sh0000001FF;
            22: v = 34'sh0000000FF;
            23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/go_to_goal_steering.sv
// Go-to-goal steering: pose in, motion command out, fully pipelined.
// Depends on gtg_pkg and go_to_goal_steering_assert.svh.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata: pos_x, pos_y, heading
//  m_       out  m_tvalid/m_tready   m_tdata: linear_speed, turn_rate; m_tuser: action
//  cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pose per cycle unless m_ stalls; the pipeline depth is set by the square-root
// chain (one root bit per stage, 25 stages) that runs beside the CORDIC steps.
// Every stage has its own valid bit; a stall on m_ holds the output and
// bubbles upstream are squeezed out, so s_tready stays high until all stages
// are full. Reset (aresetn low, synchronous) empties the pipeline and loads
// the register defaults; no clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "go_to_goal_steering_assert.svh"

module go_to_goal_steering #(
    parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = gtg_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // pose input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
    // command output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // linear_speed[15:0], turn_rate[34:16], zero pad
    output logic [1:0]       m_tuser,   // action[1:0]
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import gtg_pkg::*;

    localparam int NS = NCORE + 6;
    localparam logic [SUM_W+6:0] FAR_LIM = (SUM_W+7)'(1) << (2 * FRAC_BITS);
    localparam logic signed [EW+3:0] TURN_LIM = (EW+4)'(64'sd1073741824);
    localparam logic [MAG_W+15:0] TURN_HALF = (MAG_W+16)'(1) << 29;
    localparam logic [ROOT_W+16:0] SPD_HALF = (ROOT_W+17)'(1) << (FRAC_BITS + 7);

    // configuration registers
    logic [15:0] target_x_reg, target_y_reg, gain_reg, speed_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg    <= TARGET_X_RST;
            target_y_reg    <= TARGET_Y_RST;
            gain_reg        <= GAIN_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_X:    target_x_reg    <= cfg_data;
                REG_TARGET_Y:    target_y_reg    <= cfg_data;
                REG_GAIN:        gain_reg        <= cfg_data;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
            endcase
        end
    end

    // per-stage valid bits and ready chain
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   stg_rdy;

    assign stg_rdy[NS] = m_tready;
    for (genvar i = 0; i < NS; i++) begin : g_rdy
        assign stg_rdy[i] = !vld_reg[i] || stg_rdy[i+1];
        if (i == 0) begin : g_first
            assign vld_next[i] = stg_rdy[i] ? s_tvalid : vld_reg[i];
        end else begin : g_rest
            assign vld_next[i] = stg_rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stg_rdy[0];

    // stage 0: offsets to the goal
    diff_t diff_reg, diff_next;

    always_comb begin
        diff_next.dx   = $signed({1'b0, target_x_reg}) - $signed({1'b0, s_tdata[15:0]});
        diff_next.dy   = $signed({1'b0, target_y_reg}) - $signed({1'b0, s_tdata[31:16]});
        diff_next.head = $signed(s_tdata[47:32]);
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            diff_reg <= diff_next;
        end
    end

    // stage 1: squared distance and quadrant pre-rotation
    core_t core_reg [0:NCORE];
    core_t core_next0;
    logic signed [2*DW-1:0] sqx, sqy;
    logic [SUM_W-1:0]       sum;
    logic signed [XW-1:0]   sx, sy;

    always_comb begin
        sqx = diff_reg.dx * diff_reg.dx;
        sqy = diff_reg.dy * diff_reg.dy;
        sum = SUM_W'(unsigned'(sqx)) + SUM_W'(unsigned'(sqy));
        sx  = $signed({{(XW-DW-14){diff_reg.dx[DW-1]}}, diff_reg.dx, 14'b0});
        sy  = $signed({{(XW-DW-14){diff_reg.dy[DW-1]}}, diff_reg.dy, 14'b0});
        core_next0.rad  = {1'b0, sum, 16'b0};
        core_next0.rem  = '0;
        core_next0.root = '0;
        core_next0.head = diff_reg.head;
        core_next0.far  = 1'b0;
        if (!sx[XW-1]) begin
            core_next0.x = sx;
            core_next0.y = sy;
            core_next0.z = '0;
        end else if (!sy[XW-1]) begin
            core_next0.x = sy;
            core_next0.y = -sx;
            core_next0.z = HALF_PI_U30;
        end else begin
            core_next0.x = -sy;
            core_next0.y = sx;
            core_next0.z = -HALF_PI_U30;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[1]) begin
            core_reg[0] <= core_next0;
        end
    end

    // core stages: one root bit each, plus one CORDIC vectoring step while k < CORDIC_STEPS and ATAN_ENTRIES
    for (genvar k = 0; k < NCORE; k++) begin : g_core
        core_t                 c_in, c_out;
        logic signed [XW-1:0]  xs, ys;
        logic [REM_W+1:0]      acc, trial;
        logic [SUM_W+6:0]      s100;

        always_comb begin
            c_in  = core_reg[k];
            c_out = c_in;
            xs    = $signed(c_in.x) >>> k;
            ys    = $signed(c_in.y) >>> k;
            if (k < CORDIC_STEPS && k < ATAN_ENTRIES) begin
                if (!c_in.y[XW-1]) begin
                    c_out.x = c_in.x + ys;
                    c_out.y = c_in.y - xs;
                    c_out.z = c_in.z + atan_u30(k);
                end else begin
                    c_out.x = c_in.x - ys;
                    c_out.y = c_in.y + xs;
                    c_out.z = c_in.z - atan_u30(k);
                end
            end
            // restoring square root, top bit pair first
            acc   = {c_in.rem, c_in.rad[RAD_W-1 -: 2]};
            trial = {2'b00, c_in.root, 2'b01};
            c_out.rad = c_in.rad << 2;
            if (acc >= trial) begin
                c_out.rem  = REM_W'(acc - trial);
                c_out.root = {c_in.root[ROOT_W-2:0], 1'b1};
            end else begin
                c_out.rem  = acc[REM_W-1:0];
                c_out.root = {c_in.root[ROOT_W-2:0], 1'b0};
            end
            // far test: 100 * sum > 2^(2*FRAC_BITS), on the unshifted radicand
            s100 = ({7'b0, c_in.rad[RAD_W-2 -: SUM_W]} << 6)
                 + ({7'b0, c_in.rad[RAD_W-2 -: SUM_W]} << 5)
                 + ({7'b0, c_in.rad[RAD_W-2 -: SUM_W]} << 2);
            c_out.far = (k == 0) ? (s100 > FAR_LIM) : c_in.far;
        end

        always_ff @(posedge aclk) begin
            if (stg_rdy[k+2]) begin
                core_reg[k+1] <= c_out;
            end
        end
    end

    // heading error
    err_t err_reg, err_next;
    core_t core_last;

    always_comb begin
        core_last     = core_reg[NCORE];
        err_next.err  = $signed({core_last.z[XW-1], core_last.z})
                      - $signed({{2{core_last.head[15]}}, core_last.head, 17'b0});
        err_next.root = core_last.root;
        err_next.far  = core_last.far;
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[NCORE+2]) begin
            err_reg <= err_next;
        end
    end

    // magnitude and turn test: 10 * |err| > 2^30
    mag_t mag_reg, mag_next;
    logic signed [EW+3:0] err10;
    logic signed [EW-1:0] err_neg;

    always_comb begin
        err10   = ((EW+4)'(err_reg.err) <<< 3) + ((EW+4)'(err_reg.err) <<< 1);
        err_neg = -err_reg.err;
        mag_next.neg  = err_reg.err[EW-1];
        mag_next.mag  = mag_next.neg ? MAG_W'(unsigned'(err_neg))
                                     : MAG_W'(unsigned'(err_reg.err));
        mag_next.turn = mag_next.neg ? (err10 < -TURN_LIM) : (err10 > TURN_LIM);
        mag_next.root = err_reg.root;
        mag_next.far  = err_reg.far;
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[NCORE+3]) begin
            mag_reg <= mag_next;
        end
    end

    // gain products
    prod_t prod_reg, prod_next;

    always_comb begin
        prod_next.pt   = gain_reg * mag_reg.mag;
        prod_next.ps   = gain_reg * mag_reg.root;
        prod_next.neg  = mag_reg.neg;
        prod_next.turn = mag_reg.turn;
        prod_next.far  = mag_reg.far;
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[NCORE+4]) begin
            prod_reg <= prod_next;
        end
    end

    // rounding, saturation and command select into the output register
    cmd_t cmd_reg, cmd_next;
    logic [MAG_W+15:0]      t_rnd;
    logic [19:0]            t_mag;
    logic signed [TURN_W-1:0] t_sat;
    logic [ROOT_W+16:0]     s_rnd, s_val;

    always_comb begin
        t_rnd = prod_reg.pt + TURN_HALF;
        t_mag = t_rnd[MAG_W+15 -: 20];
        if (prod_reg.neg) begin
            t_sat = (t_mag > 20'd262144) ? $signed(19'h40000) : $signed(19'(-t_mag));
        end else begin
            t_sat = (t_mag > 20'd262143) ? $signed(19'h3FFFF) : $signed(t_mag[18:0]);
        end
        s_rnd = {1'b0, prod_reg.ps} + SPD_HALF;
        s_val = s_rnd >> (FRAC_BITS + 8);

        cmd_next.speed  = '0;
        cmd_next.turn   = '0;
        cmd_next.action = ACT_STOP;
        if (prod_reg.far) begin
            if (prod_reg.turn) begin
                cmd_next.turn   = t_sat;
                cmd_next.action = ACT_TURN;
            end else begin
                cmd_next.speed  = (s_val > (ROOT_W+17)'(speed_limit_reg))
                                ? speed_limit_reg : s_val[15:0];
                cmd_next.action = ACT_DRIVE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[NCORE+5]) begin
            cmd_reg <= cmd_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {5'b0, cmd_reg.turn, cmd_reg.speed};
    assign m_tuser  = cmd_reg.action;

    // terms for the checks
    logic out_stop, out_drive, drive_ok, s0_stall;

    assign out_stop  = m_tvalid && (m_tuser == ACT_STOP);
    assign out_drive = m_tvalid && (m_tuser == ACT_DRIVE);
    assign drive_ok  = (cmd_reg.turn == '0) && (cmd_reg.speed <= speed_limit_reg);
    assign s0_stall  = vld_reg[0] && !stg_rdy[1];

    // checks
    `GTG_ASSERT_IMPL(a_stop_zero, aclk, aresetn, out_stop, m_tdata == '0)
    `GTG_ASSERT_IMPL(a_drive_cmd, aclk, aresetn, out_drive, drive_ok)
    `GTG_ASSERT_IMPL(a_full_stall, aclk, aresetn, !s_tready, &vld_reg)
    `GTG_ASSERT_NEXT(a_s0_hold, aclk, aresetn, s0_stall, vld_reg[0] && $stable(diff_reg))

endmodule

`default_nettype wire

// File: bench/go_to_goal_steering_check.sv
// Checker for go_to_goal_steering: watches the pose, command and register
// channels, predicts each command and compares it field by field.
// Depends on gtg_pkg for the command struct, action codes and register indexes.
`timescale 1ns / 1ps

module go_to_goal_steering_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // pos_x[15:0], pos_y[31:16], heading[47:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // linear_speed[15:0], turn_rate[34:16], zero pad
    input  logic [1:0]  m_tuser,    // action[1:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import gtg_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int STEPS   = CORDIC_STEPS_DEF;
    localparam int MAX_LOG = 50;

    // atan(2^-i) truncated, units of 2^-30 rad
    longint arctan_u30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // shadow copies of the block's registers
    logic [15:0] goal_x = TARGET_X_RST;
    logic [15:0] goal_y = TARGET_Y_RST;
    logic [15:0] kp     = GAIN_RST;
    logic [15:0] vmax   = SPEED_LIMIT_RST;

    cmd_t cmd_q [$];
    int   errs = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        errs++;
        if (errs <= MAX_LOG)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // exact integer square root, bit pair at a time
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0) begin
            if (v >= res + one) begin
                v   = v - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // expected command for one pose under the current register values
    function automatic cmd_t steer_cmd(input logic [15:0] cx, input logic [15:0] cy,
                                       input logic [15:0] hraw);
        cmd_t            c;
        longint          dx, dy, x, y, z, xs, ys, t, err, turn_v;
        longint unsigned sum, mag, p, r, root_v, spd;
        c.speed  = '0;
        c.turn   = '0;
        c.action = ACT_STOP;
        dx  = longint'(goal_x) - longint'(cx);
        dy  = longint'(goal_y) - longint'(cy);
        sum = dx * dx + dy * dy;
        if (sum * 100 > (64'd1 << (2 * FRAC))) begin
            // bearing by CORDIC vectoring, left half plane rotated first
            x = dx * 16384;
            y = dy * 16384;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = 64'sd1686629714;
                end else begin
                    x = -y;
                    y = t;
                    z = -64'sd1686629714;
                end
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_u30[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_u30[i];
                end
            end
            // heading error, not wrapped
            err = z - longint'($signed(hraw)) * 131072;
            mag = (err < 0) ? -err : err;
            if (mag * 10 > (64'd1 << 30)) begin
                p = longint'(kp) * mag;
                r = (p + (64'd1 << 29)) >> 30;
                if (err < 0)
                    turn_v = (r > 262144) ? -262144 : -longint'(r);
                else
                    turn_v = (r > 262143) ? 262143 : longint'(r);
                c.turn   = turn_v[18:0];
                c.action = ACT_TURN;
            end else begin
                root_v = int_sqrt(sum << 16);
                p      = longint'(kp) * root_v;
                spd    = (p + (64'd1 << (FRAC + 7))) >> (FRAC + 8);
                if (spd > vmax)
                    spd = vmax;
                c.speed  = spd[15:0];
                c.action = ACT_DRIVE;
            end
        end
        return c;
    endfunction

    // follow register writes, queue predictions, compare commands
    always @(posedge aclk) begin
        cmd_t want;
        if (!aresetn) begin
            goal_x = TARGET_X_RST;
            goal_y = TARGET_Y_RST;
            kp     = GAIN_RST;
            vmax   = SPEED_LIMIT_RST;
            cmd_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_TARGET_X:    goal_x = cfg_data;
                    REG_TARGET_Y:    goal_y = cfg_data;
                    REG_GAIN:        kp     = cfg_data;
                    REG_SPEED_LIMIT: vmax   = cfg_data;
                    default: ;
                endcase
            end
            // a command leaving now belongs to an older pose
            if (m_tvalid && m_tready) begin
                if (cmd_q.size() == 0) begin
                    note_mismatch("command with no pose pending",
                                  longint'(m_tdata[34:0]), 64'sd0);
                end else begin
                    want = cmd_q.pop_front();
                    if (m_tdata[15:0] != want.speed)
                        note_mismatch("linear_speed", longint'(m_tdata[15:0]),
                                      longint'(want.speed));
                    if (m_tdata[34:16] != want.turn)
                        note_mismatch("turn_rate", longint'($signed(m_tdata[34:16])),
                                      longint'(want.turn));
                    if (m_tuser != want.action)
                        note_mismatch("action", longint'(m_tuser), longint'(want.action));
                    if (m_tdata[39:35] != '0)
                        note_mismatch("tdata pad", longint'(m_tdata[39:35]), 64'sd0);
                end
            end
            if (s_tvalid && s_tready)
                cmd_q.push_back(steer_cmd(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
        end
        fail_count <= errs;
        pending    <= cmd_q.size();
    end

endmodule

// File: bench/go_to_goal_steering_test.sv
// Top of the go_to_goal_steering testbench: clock, reset, pose and register
// stimulus, output back-pressure, watchdog and verdict.
// Depends on gtg_pkg, go_to_goal_steering and go_to_goal_steering_check.
`timescale 1ns / 1ps

module go_to_goal_steering_test;
    import gtg_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int WD_LIMIT    = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [15:0] POS_MAX = 16'd49151;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;    // pos_x[15:0], pos_y[31:16], heading[47:32]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // linear_speed[15:0], turn_rate[34:16], zero pad
    logic [1:0]  m_tuser;           // action[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TARGET_X;
    logic [15:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // goal as last written, used to aim poses
    logic [15:0] aim_x = TARGET_X_RST;
    logic [15:0] aim_y = TARGET_Y_RST;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    go_to_goal_steering u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    go_to_goal_steering_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // random back-pressure on the command channel
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WD_LIMIT);
        $display("go_to_goal_steering verification failed");
        $finish;
    end

    function automatic logic [15:0] clip_pos(input int v);
        if (v < 0)
            return 16'd0;
        if (v > POS_MAX)
            return POS_MAX;
        return v[15:0];
    endfunction

    // heading near the bearing to the goal, within about +-0.1 rad
    function automatic logic [15:0] aim_heading(input logic [15:0] px, input logic [15:0] py);
        real ang;
        int  hv;
        ang = $atan2(real'(int'(aim_y) - int'(py)), real'(int'(aim_x) - int'(px)));
        hv  = $rtoi(ang * 8192.0) + int'($urandom_range(1640)) - 820;
        if (hv > 32767)
            hv = 32767;
        if (hv < -32768)
            hv = -32768;
        return hv[15:0];
    endfunction

    function automatic logic [15:0] pick_edge_pos();
        case ($urandom_range(2))
            0:       return 16'd0;
            1:       return POS_MAX;
            default: return 16'($urandom_range(POS_MAX));
        endcase
    endfunction

    // one pose transaction, with random idle cycles in front
    task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] hd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hd, py, px};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_random_pose();
        logic [15:0] px, py, hd;
        int          mode;
        mode = $urandom_range(99);
        if (mode < 30) begin
            // facing the goal: mostly drive commands
            px = 16'($urandom_range(POS_MAX));
            py = 16'($urandom_range(POS_MAX));
            hd = aim_heading(px, py);
        end else if (mode < 45) begin
            // close to the goal: stop, short drive or turn
            px = clip_pos(int'(aim_x) + int'($urandom_range(800)) - 400);
            py = clip_pos(int'(aim_y) + int'($urandom_range(800)) - 400);
            hd = $urandom_range(1) ? aim_heading(px, py) : 16'($urandom);
        end else if (mode < 90) begin
            px = 16'($urandom_range(POS_MAX));
            py = 16'($urandom_range(POS_MAX));
            hd = 16'($urandom);
        end else begin
            px = pick_edge_pos();
            py = pick_edge_pos();
            case ($urandom_range(2))
                0:       hd = 16'h8000;
                1:       hd = 16'h7FFF;
                default: hd = 16'h0000;
            endcase
        end
        send_pose(px, py, hd);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // all four registers, written only with the pipeline empty
    task automatic load_goal(input logic [15:0] tx, input logic [15:0] ty,
                             input logic [15:0] kp, input logic [15:0] vmax);
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_GAIN, kp);
        write_reg(REG_SPEED_LIMIT, vmax);
        cfg_valid <= 1'b0;
        aim_x = tx;
        aim_y = ty;
    endtask

    initial begin
        logic [15:0] tx, ty, kp, vmax;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed poses against the reset goal (1.0, 1.0)
        send_pose(16'd0, 16'd0, 16'd0);
        send_pose(POS_MAX, POS_MAX, 16'h8000);
        send_pose(POS_MAX, 16'd0, 16'h7FFF);
        send_pose(16'd0, POS_MAX, 16'h8000);
        send_pose(16'd4096, 16'd4096, 16'h7FFF);     // on the goal
        send_pose(16'd4096, 16'd4096, 16'h8000);
        send_pose(16'd4505, 16'd4096, 16'd0);        // just inside 0.1
        send_pose(16'd4506, 16'd4096, 16'd25736);    // just outside, facing back
        send_pose(16'd3686, 16'd4096, 16'd0);        // just outside, facing goal
        send_pose(16'd0, 16'd4096, 16'd819);         // heading error at the edge
        send_pose(16'd0, 16'd4096, 16'd820);
        send_pose(16'd0, 16'd4096, -16'sd819);
        send_pose(16'd0, 16'd4096, -16'sd820);
        send_pose(16'd8192, 16'd8192, 16'h8000);     // goal behind and below
        send_pose(16'd4096, 16'd0, 16'd12868);       // straight ahead, +pi/2
        send_pose(16'd4096, 16'd8192, -16'sd12868);  // straight ahead, -pi/2
        send_pose(16'd8192, 16'd0, 16'd0);

        // random phases, each with its own register values; idling pattern picked by ph % 4
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin tx = 16'd24576; ty = 16'd24576; kp = 16'd4096;  vmax = 16'd12288; end
                1: begin tx = 16'd1;     ty = POS_MAX;   kp = 16'd32768; vmax = 16'hFFFF;  end
                2: begin tx = POS_MAX;   ty = 16'd1;     kp = 16'hFFFF;  vmax = 16'd0;     end
                3: begin tx = 16'd0;     ty = 16'd0;     kp = 16'd0;     vmax = 16'hFFFF;  end
                4: begin tx = 16'hFFFF;  ty = 16'hFFFF;  kp = 16'd8192;  vmax = 16'd20000; end
                5: begin
                    tx   = 16'($urandom_range(49151, 1));
                    ty   = 16'($urandom_range(49151, 1));
                    kp   = 16'($urandom_range(32768));
                    vmax = 16'($urandom);
                end
                6: begin
                    tx   = 16'($urandom);
                    ty   = 16'($urandom);
                    kp   = 16'($urandom);
                    vmax = 16'($urandom);
                end
                default: begin
                    tx = 16'd12288; ty = 16'd36864; kp = 16'd20480; vmax = 16'd4096;
                end
            endcase
            load_goal(tx, ty, kp, vmax);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_pose();
        end

        // drain, then let the pipeline run out
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("go_to_goal_steering verification clean");
        else
            $display("go_to_goal_steering verification failed");
        $finish;
    end

endmodule
